// ===== hw/rtl/bcu_pkg.sv =====
// Shared types, constants and the microcode program of the BEKK covariance update.
// No dependencies; used by the sequencer, the datapath and the top level.
package bcu_pkg;

   localparam int Q_W     = 32;   // Q16.16 covariance entries
   localparam int COEF_W  = 16;   // Q2.14 matrix entries, Q4.12 returns
   localparam int PROD_W  = Q_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int COEF_N  = 12;   // C, A and B, four entries each
   localparam int SCR_N   = 24;   // scratch entries, the covariance first
   localparam int SCR_AW  = 5;
   localparam int COEF_AW = 4;
   localparam int PC_W    = 6;
   localparam int COV_N   = 4;

   typedef logic signed [Q_W-1:0]    q16_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   localparam q16_type ONE_Q16 = 32'sd65536;
   localparam q16_type SAT_MAX = 32'sh7fff_ffff;
   localparam q16_type SAT_MIN = 32'sh8000_0000;

   // configuration register indexes
   localparam logic [1:0] CSR_C = 2'd0;
   localparam logic [1:0] CSR_A = 2'd1;
   localparam logic [1:0] CSR_B = 2'd2;

   // multiplier operand sources
   localparam logic [1:0] OPA_SCR  = 2'd0;
   localparam logic [1:0] OPA_COEF = 2'd1;
   localparam logic [1:0] OPA_RET  = 2'd2;
   localparam logic [1:0] OPB_COEF = 2'd0;
   localparam logic [1:0] OPB_RET  = 2'd1;
   localparam logic [1:0] OPB_ONE  = 2'd2;

   // product scaling
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_8  = 2'd1;
   localparam logic [1:0] SH_12 = 2'd2;
   localparam logic [1:0] SH_14 = 2'd3;

   // sequencer jumps
   localparam logic [1:0] JMP_NONE = 2'd0;
   localparam logic [1:0] JMP_WAIT = 2'd1;
   localparam logic [1:0] JMP_HOME = 2'd2;

   // scratch map
   localparam logic [SCR_AW-1:0] ADR_H   = 5'd0;
   localparam logic [SCR_AW-1:0] ADR_CC  = 5'd4;
   localparam logic [SCR_AW-1:0] ADR_O   = 5'd8;
   localparam logic [SCR_AW-1:0] ADR_T   = 5'd12;
   localparam logic [SCR_AW-1:0] ADR_AOA = 5'd16;
   localparam logic [SCR_AW-1:0] ADR_BHB = 5'd20;

   // coefficient map
   localparam logic [COEF_AW-1:0] CO_C = 4'd0;
   localparam logic [COEF_AW-1:0] CO_A = 4'd4;
   localparam logic [COEF_AW-1:0] CO_B = 4'd8;

   localparam logic [PC_W-1:0] STEP_IDLE = 6'd0;

   typedef struct packed {
      logic [1:0]         a_sel;
      logic [SCR_AW-1:0]  a_idx;
      logic [1:0]         b_sel;
      logic [COEF_AW-1:0] b_idx;
      logic [1:0]         shift;
      logic               first;
      logic               wr;
      logic [SCR_AW-1:0]  waddr;
      logic [1:0]         jump;
   } ucode_type;

   function automatic ucode_type uc_mac(input logic [1:0] a_sel, input logic [SCR_AW-1:0] a_idx,
                                        input logic [1:0] b_sel, input logic [COEF_AW-1:0] b_idx,
                                        input logic [1:0] shift, input logic first, input logic wr,
                                        input logic [SCR_AW-1:0] waddr);
      ucode_type w;
      w.a_sel = a_sel;
      w.a_idx = a_idx;
      w.b_sel = b_sel;
      w.b_idx = b_idx;
      w.shift = shift;
      w.first = first;
      w.wr    = wr;
      w.waddr = waddr;
      w.jump  = JMP_NONE;
      return w;
   endfunction

   function automatic ucode_type uc_jump(input logic [1:0] jump);
      ucode_type w;
      w       = '0;
      w.a_sel = OPA_SCR;
      w.b_sel = OPB_ONE;
      w.jump  = jump;
      return w;
   endfunction

   // One control word per step. A scratch entry written by a step is not read before
   // that write has landed (the write is made from the retire stage, behind the issue registers).
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         6'd0:  w = uc_jump(JMP_WAIT);
         // C*C'
         6'd1:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd0), OPB_COEF, CO_C + 4'd0, SH_12, 1'b1, 1'b0, ADR_CC);
         6'd2:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd1), OPB_COEF, CO_C + 4'd1, SH_12, 1'b0, 1'b1,
                           ADR_CC + 5'd0);
         6'd3:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd0), OPB_COEF, CO_C + 4'd2, SH_12, 1'b1, 1'b0, ADR_CC);
         6'd4:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd1), OPB_COEF, CO_C + 4'd3, SH_12, 1'b0, 1'b1,
                           ADR_CC + 5'd1);
         6'd5:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd2), OPB_COEF, CO_C + 4'd0, SH_12, 1'b1, 1'b0, ADR_CC);
         6'd6:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd3), OPB_COEF, CO_C + 4'd1, SH_12, 1'b0, 1'b1,
                           ADR_CC + 5'd2);
         6'd7:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd2), OPB_COEF, CO_C + 4'd2, SH_12, 1'b1, 1'b0, ADR_CC);
         6'd8:  w = uc_mac(OPA_COEF, 5'(CO_C + 4'd3), OPB_COEF, CO_C + 4'd3, SH_12, 1'b0, 1'b1,
                           ADR_CC + 5'd3);
         // outer product r*r'
         6'd9:  w = uc_mac(OPA_RET, 5'd0, OPB_RET, 4'd0, SH_8, 1'b1, 1'b1, ADR_O + 5'd0);
         6'd10: w = uc_mac(OPA_RET, 5'd0, OPB_RET, 4'd1, SH_8, 1'b1, 1'b1, ADR_O + 5'd1);
         6'd11: w = uc_mac(OPA_RET, 5'd1, OPB_RET, 4'd0, SH_8, 1'b1, 1'b1, ADR_O + 5'd2);
         6'd12: w = uc_mac(OPA_RET, 5'd1, OPB_RET, 4'd1, SH_8, 1'b1, 1'b1, ADR_O + 5'd3);
         // T = A*O
         6'd13: w = uc_mac(OPA_SCR, ADR_O + 5'd0, OPB_COEF, CO_A + 4'd0, SH_14, 1'b1, 1'b0, ADR_T);
         6'd14: w = uc_mac(OPA_SCR, ADR_O + 5'd2, OPB_COEF, CO_A + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd0);
         6'd15: w = uc_mac(OPA_SCR, ADR_O + 5'd1, OPB_COEF, CO_A + 4'd0, SH_14, 1'b1, 1'b0, ADR_T);
         6'd16: w = uc_mac(OPA_SCR, ADR_O + 5'd3, OPB_COEF, CO_A + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd1);
         6'd17: w = uc_mac(OPA_SCR, ADR_O + 5'd0, OPB_COEF, CO_A + 4'd2, SH_14, 1'b1, 1'b0, ADR_T);
         6'd18: w = uc_mac(OPA_SCR, ADR_O + 5'd2, OPB_COEF, CO_A + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd2);
         6'd19: w = uc_mac(OPA_SCR, ADR_O + 5'd1, OPB_COEF, CO_A + 4'd2, SH_14, 1'b1, 1'b0, ADR_T);
         6'd20: w = uc_mac(OPA_SCR, ADR_O + 5'd3, OPB_COEF, CO_A + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd3);
         // AOA = T*A'
         6'd21: w = uc_mac(OPA_SCR, ADR_T + 5'd0, OPB_COEF, CO_A + 4'd0, SH_14, 1'b1, 1'b0, ADR_AOA);
         6'd22: w = uc_mac(OPA_SCR, ADR_T + 5'd1, OPB_COEF, CO_A + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_AOA + 5'd0);
         6'd23: w = uc_mac(OPA_SCR, ADR_T + 5'd0, OPB_COEF, CO_A + 4'd2, SH_14, 1'b1, 1'b0, ADR_AOA);
         6'd24: w = uc_mac(OPA_SCR, ADR_T + 5'd1, OPB_COEF, CO_A + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_AOA + 5'd1);
         6'd25: w = uc_mac(OPA_SCR, ADR_T + 5'd2, OPB_COEF, CO_A + 4'd0, SH_14, 1'b1, 1'b0, ADR_AOA);
         6'd26: w = uc_mac(OPA_SCR, ADR_T + 5'd3, OPB_COEF, CO_A + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_AOA + 5'd2);
         6'd27: w = uc_mac(OPA_SCR, ADR_T + 5'd2, OPB_COEF, CO_A + 4'd2, SH_14, 1'b1, 1'b0, ADR_AOA);
         6'd28: w = uc_mac(OPA_SCR, ADR_T + 5'd3, OPB_COEF, CO_A + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_AOA + 5'd3);
         // T = B*H
         6'd29: w = uc_mac(OPA_SCR, ADR_H + 5'd0, OPB_COEF, CO_B + 4'd0, SH_14, 1'b1, 1'b0, ADR_T);
         6'd30: w = uc_mac(OPA_SCR, ADR_H + 5'd2, OPB_COEF, CO_B + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd0);
         6'd31: w = uc_mac(OPA_SCR, ADR_H + 5'd1, OPB_COEF, CO_B + 4'd0, SH_14, 1'b1, 1'b0, ADR_T);
         6'd32: w = uc_mac(OPA_SCR, ADR_H + 5'd3, OPB_COEF, CO_B + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd1);
         6'd33: w = uc_mac(OPA_SCR, ADR_H + 5'd0, OPB_COEF, CO_B + 4'd2, SH_14, 1'b1, 1'b0, ADR_T);
         6'd34: w = uc_mac(OPA_SCR, ADR_H + 5'd2, OPB_COEF, CO_B + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd2);
         6'd35: w = uc_mac(OPA_SCR, ADR_H + 5'd1, OPB_COEF, CO_B + 4'd2, SH_14, 1'b1, 1'b0, ADR_T);
         6'd36: w = uc_mac(OPA_SCR, ADR_H + 5'd3, OPB_COEF, CO_B + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_T + 5'd3);
         // BHB = T*B'
         6'd37: w = uc_mac(OPA_SCR, ADR_T + 5'd0, OPB_COEF, CO_B + 4'd0, SH_14, 1'b1, 1'b0, ADR_BHB);
         6'd38: w = uc_mac(OPA_SCR, ADR_T + 5'd1, OPB_COEF, CO_B + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_BHB + 5'd0);
         6'd39: w = uc_mac(OPA_SCR, ADR_T + 5'd0, OPB_COEF, CO_B + 4'd2, SH_14, 1'b1, 1'b0, ADR_BHB);
         6'd40: w = uc_mac(OPA_SCR, ADR_T + 5'd1, OPB_COEF, CO_B + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_BHB + 5'd1);
         6'd41: w = uc_mac(OPA_SCR, ADR_T + 5'd2, OPB_COEF, CO_B + 4'd0, SH_14, 1'b1, 1'b0, ADR_BHB);
         6'd42: w = uc_mac(OPA_SCR, ADR_T + 5'd3, OPB_COEF, CO_B + 4'd1, SH_14, 1'b0, 1'b1,
                           ADR_BHB + 5'd2);
         6'd43: w = uc_mac(OPA_SCR, ADR_T + 5'd2, OPB_COEF, CO_B + 4'd2, SH_14, 1'b1, 1'b0, ADR_BHB);
         6'd44: w = uc_mac(OPA_SCR, ADR_T + 5'd3, OPB_COEF, CO_B + 4'd3, SH_14, 1'b0, 1'b1,
                           ADR_BHB + 5'd3);
         // H = CC + AOA + BHB, each term passed through the multiplier at unity
         6'd45: w = uc_mac(OPA_SCR, ADR_CC + 5'd0,  OPB_ONE, 4'd0, SH_0, 1'b1, 1'b0, ADR_H);
         6'd46: w = uc_mac(OPA_SCR, ADR_AOA + 5'd0, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b0, ADR_H);
         6'd47: w = uc_mac(OPA_SCR, ADR_BHB + 5'd0, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b1, ADR_H + 5'd0);
         6'd48: w = uc_mac(OPA_SCR, ADR_CC + 5'd1,  OPB_ONE, 4'd0, SH_0, 1'b1, 1'b0, ADR_H);
         6'd49: w = uc_mac(OPA_SCR, ADR_AOA + 5'd1, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b0, ADR_H);
         6'd50: w = uc_mac(OPA_SCR, ADR_BHB + 5'd1, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b1, ADR_H + 5'd1);
         6'd51: w = uc_mac(OPA_SCR, ADR_CC + 5'd2,  OPB_ONE, 4'd0, SH_0, 1'b1, 1'b0, ADR_H);
         6'd52: w = uc_mac(OPA_SCR, ADR_AOA + 5'd2, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b0, ADR_H);
         6'd53: w = uc_mac(OPA_SCR, ADR_BHB + 5'd2, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b1, ADR_H + 5'd2);
         6'd54: w = uc_mac(OPA_SCR, ADR_CC + 5'd3,  OPB_ONE, 4'd0, SH_0, 1'b1, 1'b0, ADR_H);
         6'd55: w = uc_mac(OPA_SCR, ADR_AOA + 5'd3, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b0, ADR_H);
         6'd56: w = uc_mac(OPA_SCR, ADR_BHB + 5'd3, OPB_ONE, 4'd0, SH_0, 1'b0, 1'b1, ADR_H + 5'd3);
         // let the last write land before the next snapshot
         6'd57: w = uc_jump(JMP_HOME);
         default: w = uc_jump(JMP_HOME);
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/bcu_sequencer.sv =====
// Microcode sequencer: step counter, program table lookup and jumps.
// Depends on bcu_pkg for the control word and the program.
module bcu_sequencer import bcu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output ucode_type ctrl,
   output logic      idle
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   assign ctrl = ucode_rom(pc_ff);
   assign idle = (pc_ff == STEP_IDLE);

   always_comb begin
      unique case (ctrl.jump)
         JMP_NONE: pc_in = pc_ff + 1'b1;
         JMP_WAIT: pc_in = start ? pc_ff + 1'b1 : pc_ff;
         JMP_HOME: pc_in = STEP_IDLE;
         default:  pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/bcu_datapath.sv =====
// Shared multiply-accumulate datapath with scratch registers holding H and temporaries.
// Depends on bcu_pkg; driven by the control word of bcu_sequencer.
module bcu_datapath import bcu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ucode_type             ctrl,
   input  logic [4*COEF_W-1:0]   c_matrix,
   input  logic [4*COEF_W-1:0]   a_matrix,
   input  logic [4*COEF_W-1:0]   b_matrix,
   input  coef_type              ret_first,
   input  coef_type              ret_second,
   output q16_type               cov [COV_N]
);

   typedef struct packed {
      logic              first;
      logic              wr;
      logic [1:0]        shift;
      logic [SCR_AW-1:0] waddr;
   } stage_type;

   q16_type   scr_ff [SCR_N];
   coef_type  coef [COEF_N];
   coef_type  ret [2];
   q16_type   opa;
   coef_type  opb;
   prod_type  prod_in;
   prod_type  prod_ff;
   stage_type stage_ff;
   stage_type stage_in;
   prod_type  scaled;
   acc_type   addend;
   acc_type   acc_in;
   acc_type   acc_ff;
   q16_type   sat;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         coef[k]     = c_matrix[COEF_W*k +: COEF_W];
         coef[k + 4] = a_matrix[COEF_W*k +: COEF_W];
         coef[k + 8] = b_matrix[COEF_W*k +: COEF_W];
      end
      ret[0] = ret_first;
      ret[1] = ret_second;
   end

   // issue: select operands and multiply
   always_comb begin
      unique case (ctrl.a_sel)
         OPA_SCR:  opa = scr_ff[ctrl.a_idx];
         OPA_COEF: opa = Q_W'(coef[ctrl.a_idx[COEF_AW-1:0]]);
         OPA_RET:  opa = Q_W'(ret[ctrl.a_idx[0]]);
         default:  opa = '0;
      endcase
      unique case (ctrl.b_sel)
         OPB_COEF: opb = coef[ctrl.b_idx];
         OPB_RET:  opb = ret[ctrl.b_idx[0]];
         OPB_ONE:  opb = 16'sd1;
         default:  opb = '0;
      endcase
      prod_in = PROD_W'(opa) * PROD_W'(opb);
      stage_in.first = ctrl.first;
      stage_in.wr    = ctrl.wr;
      stage_in.shift = ctrl.shift;
      stage_in.waddr = ctrl.waddr;
   end

   // retire: scale, accumulate, saturate
   always_comb begin
      unique case (stage_ff.shift)
         SH_0:    scaled = prod_ff;
         SH_8:    scaled = prod_ff >>> 8;
         SH_12:   scaled = prod_ff >>> 12;
         SH_14:   scaled = prod_ff >>> 14;
         default: scaled = prod_ff;
      endcase
      addend = ACC_W'(scaled);
      acc_in = stage_ff.first ? addend : acc_ff + addend;
      if (acc_in[ACC_W-1:Q_W-1] == '0 || acc_in[ACC_W-1:Q_W-1] == '1) begin
         sat = acc_in[Q_W-1:0];
      end else begin
         sat = acc_in[ACC_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity on the diagonal of H, zero elsewhere
         for (int k = 0; k < SCR_N; k++) begin
            scr_ff[k] <= (k == int'(ADR_H) || k == int'(ADR_H) + 3) ? ONE_Q16 : '0;
         end
      end else if (stage_ff.wr) begin
         scr_ff[stage_ff.waddr] <= sat;
      end
   end

   always_comb begin
      for (int k = 0; k < COV_N; k++) begin
         cov[k] = scr_ff[k];
      end
   end

endmodule

// ===== hw/rtl/bekk_covariance_update.sv =====
// Top level of the two-asset BEKK-GARCH(1,1) covariance update.
// Depends on bcu_pkg, bcu_sequencer and bcu_datapath.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall| req_ret_first, req_ret_second (Q4.12)
//   rsp_    | out       | rsp_valid/rsp_stall| rsp_cov_00/01/10/11 (Q16.16, H before update)
//   csr_    | in        | csr_valid/csr_ready| csr_index, csr_data (C, A, B matrices)
//
// Each transaction occupies the block while the microcode program runs its 57
// steps on the one shared multiplier after the accepting cycle.
// The response register loads H at acceptance, so the update runs while it waits.
// A new transaction is taken once the program is home and the response slot frees.
// Reset is synchronous: H returns to identity, C, A and B to zero. csr_ready is always high.
module bekk_covariance_update import bcu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_ret_first,
   input  logic signed [15:0]  req_ret_second,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_cov_00,
   output logic signed [31:0]  rsp_cov_01,
   output logic signed [31:0]  rsp_cov_10,
   output logic signed [31:0]  rsp_cov_11,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data
);

   logic [63:0] c_ff;
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   coef_type    ret_first_ff;
   coef_type    ret_second_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   q16_type     cov_ff [COV_N];
   q16_type     cov [COV_N];
   ucode_type   ctrl;
   logic        idle;
   logic        accept;

   assign csr_ready = 1'b1;
   assign req_stall = !idle || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_C:   c_ff <= csr_data;
            CSR_A:   a_ff <= csr_data;
            CSR_B:   b_ff <= csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // hold the returns and snapshot H for the response
   always_ff @(posedge clock) begin
      if (accept) begin
         ret_first_ff  <= req_ret_first;
         ret_second_ff <= req_ret_second;
         for (int k = 0; k < COV_N; k++) begin
            cov_ff[k] <= cov[k];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cov_00 = cov_ff[0];
   assign rsp_cov_01 = cov_ff[1];
   assign rsp_cov_10 = cov_ff[2];
   assign rsp_cov_11 = cov_ff[3];

   bcu_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .ctrl  (ctrl),
      .idle  (idle)
   );

   bcu_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .c_matrix   (c_ff),
      .a_matrix   (a_ff),
      .b_matrix   (b_ff),
      .ret_first  (ret_first_ff),
      .ret_second (ret_second_ff),
      .cov        (cov)
   );

endmodule

// ===== hw/rtl/bcu_checker.sv =====
// Port-level checks of the covariance update's handshakes, and their bind to the top level.
// Depends only on the ports of bekk_covariance_update.
module bcu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_cov_00,
   input logic signed [31:0] rsp_cov_01,
   input logic signed [31:0] rsp_cov_10,
   input logic signed [31:0] rsp_cov_11
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cov_00) && $stable(rsp_cov_01)
                                 && $stable(rsp_cov_10) && $stable(rsp_cov_11))
      else $error("stalled response changed");

   // every accepted transaction shows its response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("response missing after accepted request");

   // the update keeps the block busy after an accepted transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("request taken while update in progress");

   // a response only appears from an accepted request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response without request");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bekk_covariance_update bcu_checker u_bcu_checker (.*);
